/* src/hhre_pkg.sv */
// Package for the Hopfield recall engine: sizes, mode codes, state type, clamp helpers.
`timescale 1ns / 1ps
package hhre_pkg;

    // network size and weight precision
    localparam int NEURONS     = 64;
    localparam int WEIGHT_BITS = 16;

    localparam int NIDX_W  = $clog2(NEURONS);
    localparam int NDEPTH  = 1 << NIDX_W;
    localparam int WADDR_W = 2 * NIDX_W;
    localparam int WDEPTH  = 1 << WADDR_W;

    // accumulator holds NEURONS^2 terms of a weight times a coefficient in -4..4
    localparam int ACC_W  = WEIGHT_BITS + 2 * NIDX_W + 3;
    localparam int WIDE_W = ((ACC_W > 30) ? ACC_W : 30) + 1;

    localparam int ACT_W = 24;
    localparam int NRG_W = 30;

    // mode codes of an input word
    localparam logic [2:0] MODE_TRAIN     = 3'd0;
    localparam logic [2:0] MODE_WR_WEIGHT = 3'd1;
    localparam logic [2:0] MODE_WR_NEURON = 3'd2;
    localparam logic [2:0] MODE_UPDATE    = 3'd3;
    localparam logic [2:0] MODE_ENERGY    = 3'd4;

    // weight range
    localparam logic signed [32:0] W_MAX = (33'sd1 <<< (WEIGHT_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] W_MIN = -W_MAX - 33'sd1;

    // result ranges
    localparam logic signed [WIDE_W-1:0] ACT_MAX = WIDE_W'(8388607);
    localparam logic signed [WIDE_W-1:0] ACT_MIN = -ACT_MAX - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] NRG_MAX = WIDE_W'(536870911);
    localparam logic signed [WIDE_W-1:0] NRG_MIN = -NRG_MAX - WIDE_W'(1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRAIN,
        ST_MAC,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // clamp a value to the signed weight range
    function automatic logic signed [WEIGHT_BITS-1:0] clamp_weight(
        input logic signed [32:0] v
    );
        logic signed [WEIGHT_BITS-1:0] r;
        if (v > W_MAX) begin
            r = W_MAX[WEIGHT_BITS-1:0];
        end else if (v < W_MIN) begin
            r = W_MIN[WEIGHT_BITS-1:0];
        end else begin
            r = v[WEIGHT_BITS-1:0];
        end
        return r;
    endfunction

    // neuron values live in -2..2
    function automatic logic signed [2:0] clamp_neuron(input logic signed [2:0] v);
        logic signed [2:0] r;
        if (v < -3'sd2) begin
            r = -3'sd2;
        end else if (v > 3'sd2) begin
            r = 3'sd2;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // saturate the weighted sum to the activation field
    function automatic logic signed [ACT_W-1:0] sat_act(input logic signed [ACC_W-1:0] a);
        logic signed [WIDE_W-1:0] w;
        logic signed [ACT_W-1:0]  r;
        w = WIDE_W'(a);
        if (w > ACT_MAX) begin
            r = ACT_MAX[ACT_W-1:0];
        end else if (w < ACT_MIN) begin
            r = ACT_MIN[ACT_W-1:0];
        end else begin
            r = w[ACT_W-1:0];
        end
        return r;
    endfunction

    // negate the quadratic form and saturate to the energy field
    function automatic logic signed [NRG_W-1:0] sat_nrg(input logic signed [ACC_W-1:0] a);
        logic signed [WIDE_W-1:0] w;
        logic signed [NRG_W-1:0]  r;
        w = -WIDE_W'(a);
        if (w > NRG_MAX) begin
            r = NRG_MAX[NRG_W-1:0];
        end else if (w < NRG_MIN) begin
            r = NRG_MIN[NRG_W-1:0];
        end else begin
            r = w[NRG_W-1:0];
        end
        return r;
    endfunction

endpackage

/* src/hopfield_hebbian_recall_engine.sv */
// Hopfield recall engine: weight and neuron stores, shared multiply-accumulate, sequencer.
`timescale 1ns / 1ps
// The engine holds a NEURONS x NEURONS weight memory and a NEURONS-entry neuron
// memory and takes one word at a time; s_ready is low while a word is being
// worked on. After reset a clearing pass zeroes both memories, one weight per
// cycle, before the first word is taken. Write-weight, write-neuron and rejected
// words go straight to the done state. Update walks one weight column through
// the shared multiply-accumulate unit, one weight per cycle. Energy walks the
// whole matrix through the same unit. Train reads, adjusts and writes back every
// off-diagonal weight over the single weight memory port pair. A finished result
// sits in the output register until m_ready takes it, and the next word is
// accepted meanwhile.
module hopfield_hebbian_recall_engine
    import hhre_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_mode,
    input  logic [63:0]              s_pattern_bits,
    input  logic [5:0]               s_row_index,
    input  logic [5:0]               s_col_index,
    input  logic signed [15:0]       s_weight_value,
    input  logic signed [2:0]        s_neuron_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [2:0]        m_new_neuron,
    output logic signed [ACT_W-1:0]  m_activation,
    output logic signed [NRG_W-1:0]  m_neg_double_energy
);

    localparam logic [NIDX_W-1:0]      IDX_LAST = NIDX_W'(NEURONS - 1);
    localparam logic [WADDR_W-1:0]     CLR_LAST = WADDR_W'(WDEPTH - 1);
    localparam logic signed [WEIGHT_BITS:0] TR_ONE = (WEIGHT_BITS + 1)'(1);

    // memories
    logic [WEIGHT_BITS-1:0] wmem [WDEPTH];
    logic [2:0]             nmem [NDEPTH];

    // control registers
    state_t                  state_reg, state_next;
    logic [WADDR_W-1:0]      clr_reg;
    logic [NIDX_W-1:0]       i_reg, j_reg;
    logic [2:0]              mode_reg;
    logic [NIDX_W-1:0]       row_reg;
    logic [NEURONS-1:0]      pat_reg;
    logic                    ok_reg;
    logic signed [2:0]       nn_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // pipeline registers
    logic                          rd_vld_reg;
    logic [NIDX_W-1:0]             rd_i_reg, rd_j_reg;
    logic signed [WEIGHT_BITS-1:0] w_rd_reg;
    logic signed [2:0]             na_rd_reg, nb_rd_reg;
    logic                          mul_vld_reg;
    logic signed [WEIGHT_BITS-1:0] w_q_reg;
    logic signed [3:0]             coef_reg;

    // output register
    logic                    m_valid_reg;
    logic signed [2:0]       m_nn_reg;
    logic signed [ACT_W-1:0] m_act_reg;
    logic signed [NRG_W-1:0] m_nrg_reg;

    // combinational control
    logic                          accept, row_ok, col_ok, issue, issue_last, out_load;
    logic                          rd_en, wr_en, nw_en;
    logic [WADDR_W-1:0]            rd_waddr, wr_addr;
    logic [NIDX_W-1:0]             rd_na_addr, rd_nb_addr, nw_addr;
    logic [WEIGHT_BITS-1:0]        wr_data;
    logic [2:0]                    nw_data;
    logic signed [WEIGHT_BITS:0]   tr_ext, tr_sum;
    logic signed [2:0]             nb_sel;
    logic signed [5:0]             coef_full;
    logic signed [WEIGHT_BITS+3:0] prod;
    logic signed [2:0]             res_nn;
    logic signed [ACT_W-1:0]       res_act;
    logic signed [NRG_W-1:0]       res_nrg;

    assign accept     = s_valid && s_ready;
    assign row_ok     = {1'b0, s_row_index} < 7'(NEURONS);
    assign col_ok     = {1'b0, s_col_index} < 7'(NEURONS);
    assign issue      = (state_reg == ST_TRAIN) || (state_reg == ST_MAC);
    assign issue_last = (mode_reg == MODE_UPDATE) ? (i_reg == IDX_LAST)
                                                  : ((i_reg == IDX_LAST) && (j_reg == IDX_LAST));
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_mode == MODE_TRAIN) begin
                        state_next = ST_TRAIN;
                    end else if (s_mode == MODE_ENERGY) begin
                        state_next = ST_MAC;
                    end else if ((s_mode == MODE_UPDATE) && row_ok) begin
                        state_next = ST_MAC;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_TRAIN, ST_MAC: begin
                if (issue_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mul_vld_reg) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // train write-back value: old weight plus or minus one
    assign tr_ext = {w_rd_reg[WEIGHT_BITS-1], w_rd_reg};
    assign tr_sum = (pat_reg[rd_i_reg] == pat_reg[rd_j_reg]) ? tr_ext + TR_ONE
                                                             : tr_ext - TR_ONE;

    // memory port control
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        rd_en      = issue;
        rd_waddr   = {i_reg, j_reg};
        rd_na_addr = i_reg;
        rd_nb_addr = j_reg;
        if (mode_reg == MODE_UPDATE) rd_waddr = {i_reg, row_reg};

        wr_en   = 1'b0;
        wr_addr = {rd_i_reg, rd_j_reg};
        wr_data = clamp_weight(33'(tr_sum));
        nw_en   = 1'b0;
        nw_addr = row_reg;
        nw_data = (acc_reg >= 0) ? 3'sd1 : -3'sd1;

        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
            nw_en   = 1'b1;
            nw_addr = clr_reg[NIDX_W-1:0];
            nw_data = '0;
        end else if (accept && (s_mode == MODE_WR_WEIGHT)) begin
            wr_en   = row_ok && col_ok;
            wr_addr = {s_row_index[NIDX_W-1:0], s_col_index[NIDX_W-1:0]};
            wr_data = clamp_weight(33'(s_weight_value));
        end else if (accept && (s_mode == MODE_WR_NEURON)) begin
            nw_en   = row_ok;
            nw_addr = s_row_index[NIDX_W-1:0];
            nw_data = clamp_neuron(s_neuron_value);
        end else begin
            wr_en = rd_vld_reg && (mode_reg == MODE_TRAIN) && (rd_i_reg != rd_j_reg);
            nw_en = out_load && (mode_reg == MODE_UPDATE) && ok_reg;
        end
    end

    // weight memory
    always_ff @(posedge aclk) begin
        if (wr_en) wmem[wr_addr] <= wr_data;
        if (rd_en) w_rd_reg <= wmem[rd_waddr];
    end

    // neuron memory, two read ports
    always_ff @(posedge aclk) begin
        if (nw_en) nmem[nw_addr] <= nw_data;
        if (rd_en) begin
            na_rd_reg <= nmem[rd_na_addr];
            nb_rd_reg <= nmem[rd_nb_addr];
        end
    end

    // coefficient: s_i for update, s_i * s_j for energy
    assign nb_sel    = (mode_reg == MODE_ENERGY) ? nb_rd_reg : 3'sd1;
    assign coef_full = na_rd_reg * nb_sel;
    assign prod      = w_q_reg * coef_reg;

    // sequencer, counters and pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg && (mode_reg != MODE_TRAIN);
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + WADDR_W'(1);
            if (accept) begin
                i_reg <= '0;
                j_reg <= '0;
            end else if (issue) begin
                if (mode_reg == MODE_UPDATE) begin
                    i_reg <= i_reg + NIDX_W'(1);
                end else if (j_reg == IDX_LAST) begin
                    j_reg <= '0;
                    i_reg <= i_reg + NIDX_W'(1);
                end else begin
                    j_reg <= j_reg + NIDX_W'(1);
                end
            end
        end
    end

    // payload registers and accumulator
    always_ff @(posedge aclk) begin
        rd_i_reg <= i_reg;
        rd_j_reg <= j_reg;
        w_q_reg  <= w_rd_reg;
        coef_reg <= coef_full[3:0];
        if (accept) begin
            mode_reg <= s_mode;
            row_reg  <= s_row_index[NIDX_W-1:0];
            pat_reg  <= s_pattern_bits[NEURONS-1:0];
            nn_reg   <= clamp_neuron(s_neuron_value);
            acc_reg  <= '0;
            case (s_mode) inside
                MODE_TRAIN, MODE_ENERGY:     ok_reg <= 1'b1;
                MODE_WR_WEIGHT:              ok_reg <= row_ok && col_ok;
                MODE_WR_NEURON, MODE_UPDATE: ok_reg <= row_ok;
                default:                     ok_reg <= 1'b0;
            endcase
        end else if (mul_vld_reg) begin
            acc_reg <= acc_reg + $signed({{(ACC_W - WEIGHT_BITS - 4){prod[WEIGHT_BITS+3]}},
                                          prod});
        end
    end

    // result fields
    always_comb begin
        res_nn  = '0;
        res_act = '0;
        res_nrg = '0;
        if (ok_reg) begin
            case (mode_reg)
                MODE_WR_NEURON: res_nn = nn_reg;
                MODE_UPDATE: begin
                    res_nn  = (acc_reg >= 0) ? 3'sd1 : -3'sd1;
                    res_act = sat_act(acc_reg);
                end
                MODE_ENERGY: res_nrg = sat_nrg(acc_reg);
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_nn_reg  <= res_nn;
            m_act_reg <= res_act;
            m_nrg_reg <= res_nrg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_new_neuron        = m_nn_reg;
    assign m_activation        = m_act_reg;
    assign m_neg_double_energy = m_nrg_reg;

`ifndef SYNTH
    // a new word only enters with the multiply pipeline empty
    a_pipe_empty_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> (!rd_vld_reg && !mul_vld_reg))
        else $error("word accepted with multiply pipeline busy");

    // train write-back never hits the weight being read in the same cycle
    a_no_rmw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && rd_en) |-> (wr_addr != rd_waddr))
        else $error("weight write and read collide");

    // a fresh result word only comes out of the done state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside done state");

    // energy words always go through the accumulate walk; update words only with a valid row
    a_mac_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_mode == MODE_ENERGY)) |=> (state_reg == ST_MAC))
        else $error("energy word skipped the accumulate walk");

    // nothing is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("ready raised during clearing pass");
`endif

endmodule
